// ===== rtl/core/brs_pkg.sv =====
// Shared types, constants and codes for the bilinear RGB sampler.
// No dependencies.
`timescale 1ns / 1ps
package brs_pkg;
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int FRACTION_BITS = 8;
    localparam int CHANNEL_BITS  = 16;
    localparam int CFG_BITS      = 9;
    localparam int COORD_BITS    = 16;
    localparam int PIX_BITS      = 8;
    localparam int OUT_BITS      = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;
endpackage

// ===== rtl/core/brs_if.sv =====
// Valid/ready channel interfaces for input items, results and register writes.
// Depends on brs_pkg.
`timescale 1ns / 1ps
interface brs_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [brs_pkg::PIX_BITS-1:0]   pixel_col;
    logic [brs_pkg::PIX_BITS-1:0]   pixel_row;
    logic [brs_pkg::OUT_BITS-1:0]   texel_red;
    logic [brs_pkg::OUT_BITS-1:0]   texel_green;
    logic [brs_pkg::OUT_BITS-1:0]   texel_blue;
    logic [brs_pkg::COORD_BITS-1:0] x_coord;
    logic [brs_pkg::COORD_BITS-1:0] y_coord;
    modport source (output valid, operation, pixel_col, pixel_row, texel_red, texel_green,
                    texel_blue, x_coord, y_coord, input ready);
    modport sink (input valid, operation, pixel_col, pixel_row, texel_red, texel_green,
                  texel_blue, x_coord, y_coord, output ready);
endinterface

interface brs_out_if;
    logic        valid;
    logic        ready;
    logic [brs_pkg::OUT_BITS-1:0] out_red;
    logic [brs_pkg::OUT_BITS-1:0] out_green;
    logic [brs_pkg::OUT_BITS-1:0] out_blue;
    logic        coord_clamped;
    modport source (output valid, out_red, out_green, out_blue, coord_clamped, input ready);
    modport sink (input valid, out_red, out_green, out_blue, coord_clamped, output ready);
endinterface

interface brs_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [brs_pkg::CFG_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/brs_front.sv =====
// Front end: accepts items, clamps sample coordinates, forms the four neighbour addresses.
// Depends on brs_pkg.
`timescale 1ns / 1ps
module brs_front #(
    parameter int MAX_WIDTH     = brs_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT    = brs_pkg::MAX_HEIGHT,
    parameter int FRACTION_BITS = brs_pkg::FRACTION_BITS,
    parameter int CHANNEL_BITS  = brs_pkg::CHANNEL_BITS,
    localparam int XB = $clog2(MAX_WIDTH),
    localparam int YB = $clog2(MAX_HEIGHT),
    localparam int PW = 1 + XB + YB + 3*CHANNEL_BITS + 2*XB + 2*YB + 2*FRACTION_BITS + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [brs_pkg::PIX_BITS-1:0]  i_pixel_col,
    input  logic [brs_pkg::PIX_BITS-1:0]  i_pixel_row,
    input  logic [brs_pkg::OUT_BITS-1:0]  i_texel_red,
    input  logic [brs_pkg::OUT_BITS-1:0]  i_texel_green,
    input  logic [brs_pkg::OUT_BITS-1:0]  i_texel_blue,
    input  logic [brs_pkg::COORD_BITS-1:0] i_x_coord,
    input  logic [brs_pkg::COORD_BITS-1:0] i_y_coord,
    input  logic [brs_pkg::CFG_BITS-1:0]  i_width,
    input  logic [brs_pkg::CFG_BITS-1:0]  i_height,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [PW-1:0]                 o_payload
);
    localparam int WB = (XB > YB ? XB : YB) + 2;
    localparam int IB = brs_pkg::COORD_BITS - FRACTION_BITS;
    localparam int CB = WB > IB ? WB : IB;

    logic [PW-1:0] r_q [brs_pkg::QUEUE_DEPTH];
    logic [1:0]    r_cnt;
    logic          r_rp, r_wp;
    logic [PW-1:0] n_item;
    logic          w_push, w_pop;

    logic [CB-1:0] w_w, w_h, w_xi, w_yi, w_x0, w_y0, w_x1, w_y1;
    logic          w_cx, w_cy;
    logic          w_wr_ok;
    logic [XB-1:0] w_wcol;
    logic [YB-1:0] w_wrow;

    always_comb begin
        w_w = CB'(i_width);
        if (i_width == '0) w_w = CB'(1);
        else if (CB'(i_width) > CB'(MAX_WIDTH)) w_w = CB'(MAX_WIDTH);
        w_h = CB'(i_height);
        if (i_height == '0) w_h = CB'(1);
        else if (CB'(i_height) > CB'(MAX_HEIGHT)) w_h = CB'(MAX_HEIGHT);
        w_xi = CB'(i_x_coord[brs_pkg::COORD_BITS-1:FRACTION_BITS]);
        w_yi = CB'(i_y_coord[brs_pkg::COORD_BITS-1:FRACTION_BITS]);
        w_cx = w_xi >= w_w;
        w_cy = w_yi >= w_h;
        w_x0 = w_cx ? w_w - CB'(1) : w_xi;
        w_y0 = w_cy ? w_h - CB'(1) : w_yi;
        w_x1 = (w_x0 + CB'(1) >= w_w) ? '0 : w_x0 + CB'(1);
        w_y1 = (w_y0 + CB'(1) >= w_h) ? w_h - CB'(1) : w_y0 + CB'(1);
        w_wr_ok = (32'(i_pixel_col) < MAX_WIDTH) && (32'(i_pixel_row) < MAX_HEIGHT);
        w_wcol = XB'(i_pixel_col);
        w_wrow = YB'(i_pixel_row);
        n_item = {i_operation == brs_pkg::OP_WRITE && w_wr_ok, w_wcol, w_wrow,
                  CHANNEL_BITS'(i_texel_red), CHANNEL_BITS'(i_texel_green),
                  CHANNEL_BITS'(i_texel_blue),
                  w_x0[XB-1:0], w_x1[XB-1:0], w_y0[YB-1:0], w_y1[YB-1:0],
                  i_x_coord[FRACTION_BITS-1:0], i_y_coord[FRACTION_BITS-1:0],
                  w_cx || w_cy, i_operation == brs_pkg::OP_SAMPLE};
    end

    assign o_ready   = r_cnt != 2'd2;
    assign o_valid   = r_cnt != 2'd0;
    assign o_payload = r_q[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_q[r_wp] <= n_item;
    end
endmodule

// ===== rtl/core/brs_back.sv =====
// Back end: parity-banked texel store read at two columns per bank, bilinear blend pipeline.
// Depends on brs_pkg.
`timescale 1ns / 1ps
module brs_back #(
    parameter int MAX_WIDTH     = brs_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT    = brs_pkg::MAX_HEIGHT,
    parameter int FRACTION_BITS = brs_pkg::FRACTION_BITS,
    parameter int CHANNEL_BITS  = brs_pkg::CHANNEL_BITS,
    localparam int XB = $clog2(MAX_WIDTH),
    localparam int YB = $clog2(MAX_HEIGHT),
    localparam int PW = 1 + XB + YB + 3*CHANNEL_BITS + 2*XB + 2*YB + 2*FRACTION_BITS + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [PW-1:0]                i_payload,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [brs_pkg::OUT_BITS-1:0] o_red,
    output logic [brs_pkg::OUT_BITS-1:0] o_green,
    output logic [brs_pkg::OUT_BITS-1:0] o_blue,
    output logic                         o_clamped
);
    localparam int F  = FRACTION_BITS;
    localparam int C  = CHANNEL_BITS;
    localparam int TW = 3*C;
    localparam int HB = C + F + 1;
    localparam int VB = C + 2*F + 2;
    localparam int BX = (MAX_WIDTH + 1) / 2;
    localparam int BY = (MAX_HEIGHT + 1) / 2;
    localparam int BD = BX * BY;
    localparam int AB = $clog2(BD) > 0 ? $clog2(BD) : 1;
    localparam int LAT = 4;

    logic          w_wr;
    logic [XB-1:0] w_wc, x0, x1;
    logic [YB-1:0] w_wrr, y0, y1;
    logic [TW-1:0] w_wd;
    logic [F-1:0]  w_fx, w_fy;
    logic          w_cl;
    logic          w_samp;
    assign {w_wr, w_wc, w_wrr, w_wd, x0, x1, y0, y1, w_fx, w_fy, w_cl, w_samp} = i_payload;

    // pipeline stall: a stage moves when the one after it is free
    logic [LAT-1:0] r_v;
    logic [LAT-1:0] w_adv;
    logic           w_take;
    always_comb begin
        w_adv[LAT-1] = !r_v[LAT-1] || i_ready;
        for (int s = LAT-2; s >= 0; s--) w_adv[s] = !r_v[s] || w_adv[s+1];
    end
    assign o_ready = w_adv[0];
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_v[LAT-1];

    function automatic logic [AB-1:0] baddr(input logic [XB-1:0] c, input logic [YB-1:0] r);
        baddr = AB'((32'(r) >> 1) * BX + (32'(c) >> 1));
    endfunction

    logic [TW-1:0] r_mem [4][BD];
    logic [TW-1:0] r_rda [4];
    logic [TW-1:0] r_rdb [4];
    logic [F-1:0]  r_fx1, r_fy1;
    logic          r_cl1;
    logic [3:0]    r_par1;

    // bank b holds texels whose {row, col} parity equals b; port a reads x0, port b reads x1
    logic [AB-1:0] w_ra [4];
    logic [AB-1:0] w_rb [4];
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            logic [YB-1:0] rr;
            rr = (y0[0] == b[1]) ? y0 : y1;
            w_ra[b] = baddr(x0, rr);
            w_rb[b] = baddr(x1, rr);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (w_take && w_wr && w_wc[0] == b[0] && w_wrr[0] == b[1])
                r_mem[b][baddr(w_wc, w_wrr)] <= w_wd;
            if (w_adv[0]) begin
                r_rda[b] <= r_mem[b][w_ra[b]];
                r_rdb[b] <= r_mem[b][w_rb[b]];
            end
        end
        if (w_adv[0]) begin
            r_fx1  <= w_fx;
            r_fy1  <= w_fy;
            r_cl1  <= w_cl;
            r_par1 <= {y1[0], y0[0], x1[0], x0[0]};
        end
    end

    // route banks back to corner order: 0 = x0y0, 1 = x1y0, 2 = x0y1, 3 = x1y1
    logic [TW-1:0] w_cor [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [1:0] bk;
            bk = {k[1] ? r_par1[3] : r_par1[2], k[0] ? r_par1[1] : r_par1[0]};
            w_cor[k] = k[0] ? r_rdb[bk] : r_rda[bk];
        end
    end

    logic [HB-1:0] r_up [3], r_dn [3];
    logic [F-1:0]  r_fy2;
    logic [F:0]    w_ix;
    assign w_ix = (F+1)'(1 << F) - (F+1)'(r_fx1);
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int c = 0; c < 3; c++) begin
                r_up[c] <= HB'(w_ix * w_cor[0][TW-1-c*C -: C]) + HB'(r_fx1 * w_cor[1][TW-1-c*C -: C]);
                r_dn[c] <= HB'(w_ix * w_cor[2][TW-1-c*C -: C]) + HB'(r_fx1 * w_cor[3][TW-1-c*C -: C]);
            end
            r_fy2 <= r_fy1;
        end
    end

    logic [VB-1:0] r_va [3], r_vb [3];
    logic [F:0]    w_iy;
    assign w_iy = (F+1)'(1 << F) - (F+1)'(r_fy2);
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            for (int c = 0; c < 3; c++) begin
                r_va[c] <= VB'(w_iy * r_up[c]);
                r_vb[c] <= VB'(r_fy2 * r_dn[c]);
            end
        end
    end

    logic [VB-1:0] w_sum [3];
    logic [brs_pkg::OUT_BITS-1:0] r_o [3];
    always_comb begin
        for (int c = 0; c < 3; c++) w_sum[c] = (r_va[c] + r_vb[c]) >> (2*F);
    end
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int c = 0; c < 3; c++) r_o[c] <= brs_pkg::OUT_BITS'(w_sum[c]);
        end
    end
    assign o_red   = r_o[0];
    assign o_green = r_o[1];
    assign o_blue  = r_o[2];

    // clamp flag travels alongside
    logic r_c2, r_c3, r_c4;
    assign o_clamped = r_c4;
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) r_c2 <= r_cl1;
        if (w_adv[2]) r_c3 <= r_c2;
        if (w_adv[3]) r_c4 <= r_c3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= w_take && w_samp;
            for (int s = 1; s < LAT; s++)
                if (w_adv[s]) r_v[s] <= r_v[s-1];
        end
    end
endmodule

// ===== rtl/core/bilinear_rgb_sampler_core.sv =====
// Bilinear RGB texture sampler: a front end that clamps coordinates, a two-entry queue
// and a back end with a parity-banked texel store and blend pipeline.
// An item is taken every cycle while the queue has room; a sample result is offered after
// it passes the queue entry, the store read and three multiply/add stages.
// Depends on brs_pkg, brs_if.
`timescale 1ns / 1ps
module bilinear_rgb_sampler_core #(
    parameter int MAX_WIDTH     = brs_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT    = brs_pkg::MAX_HEIGHT,
    parameter int FRACTION_BITS = brs_pkg::FRACTION_BITS,
    parameter int CHANNEL_BITS  = brs_pkg::CHANNEL_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brs_in_if.sink     s_in,
    brs_out_if.source  m_out,
    brs_cfg_if.sink    s_cfg
);
    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int PW = 1 + XB + YB + 3*CHANNEL_BITS + 2*XB + 2*YB + 2*FRACTION_BITS + 2;

    logic [brs_pkg::CFG_BITS-1:0] r_width, r_height;
    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= brs_pkg::CFG_BITS'(256);
            r_height <= brs_pkg::CFG_BITS'(256);
        end else if (s_cfg.valid && s_cfg.index[7:1] == '0) begin
            if (s_cfg.index[0] == brs_pkg::REG_WIDTH) r_width <= s_cfg.data;
            else r_height <= s_cfg.data;
        end
    end

    logic          w_qv, w_qr;
    logic [PW-1:0] w_qd;

    brs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
                .FRACTION_BITS(FRACTION_BITS), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_operation(s_in.operation), .i_pixel_col(s_in.pixel_col),
        .i_pixel_row(s_in.pixel_row), .i_texel_red(s_in.texel_red),
        .i_texel_green(s_in.texel_green), .i_texel_blue(s_in.texel_blue),
        .i_x_coord(s_in.x_coord), .i_y_coord(s_in.y_coord),
        .i_width(r_width), .i_height(r_height),
        .o_valid(w_qv), .i_ready(w_qr), .o_payload(w_qd)
    );

    brs_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
               .FRACTION_BITS(FRACTION_BITS), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_payload(w_qd),
        .o_valid(m_out.valid), .i_ready(m_out.ready),
        .o_red(m_out.out_red), .o_green(m_out.out_green), .o_blue(m_out.out_blue),
        .o_clamped(m_out.coord_clamped)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.out_red))
        else $error("result changed while stalled");
    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_qv |-> s_in.ready)
        else $error("front stalled with empty queue");
endmodule
